// ----- hdl/kinetic_scroll_controller_assert.svh -----
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef KINETIC_SCROLL_CONTROLLER_ASSERT_SVH
`define KINETIC_SCROLL_CONTROLLER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define KSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kinetic scroll check failed");

// Consequent holds in the cycle after the antecedent.
`define KSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kinetic scroll check failed");

`endif

// ----- hdl/ksc_pkg.sv -----
package ksc_pkg;

  localparam int POS_BITS  = 16;
  localparam int FRAC_BITS = 8;
  localparam int SCR_BITS  = POS_BITS + FRAC_BITS + 1;
  localparam int MAXS_W    = 10;
  localparam int STEPS_W   = 5;
  localparam int MAG_W     = MAXS_W + FRAC_BITS;
  localparam int CNT_W     = $clog2(MAG_W);

  localparam logic [MAXS_W-1:0]  MAX_SPEED_RST   = MAXS_W'(100);
  localparam logic [STEPS_W-1:0] DECEL_STEPS_RST = STEPS_W'(20);

  typedef enum logic [1:0] {
    MODE_STEADY  = 2'd0,
    MODE_PRESSED = 2'd1,
    MODE_MANUAL  = 2'd2,
    MODE_AUTO    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MOVE    = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic {
    CFG_MAX_SPEED   = 1'b0,
    CFG_DECEL_STEPS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DONE
  } seq_state_t;

endpackage

// ----- hdl/ksc_div.sv -----
module ksc_div
  import ksc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MAG_W-1:0]   dividend,
  input  logic [STEPS_W-1:0] divisor,
  output logic               done,
  output logic [MAG_W-1:0]   quotient
);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [STEPS_W-1:0] dvsr;
  logic [STEPS_W-1:0] rem;
  logic [MAG_W-1:0]   quo;
  logic [STEPS_W:0]   trial;
  logic [STEPS_W:0]   diff;
  logic               ge;

  assign trial    = {rem, quo[MAG_W-1]};
  assign ge       = trial >= {1'b0, dvsr};
  assign diff     = trial - {1'b0, dvsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one restoring step per cycle, quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      rem  <= '0;
      quo  <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];
      quo <= {quo[MAG_W-2:0], ge};
    end
  end

endmodule

// ----- hdl/kinetic_scroll_controller.sv -----
// channel   signals                                   direction
// in        in_valid, in_ready, op, pos_x, pos_y      request in
// out       out_valid, out_ready, scroll_valid,
//           scroll_dx, scroll_dy, mode                request out
// cfg       cfg_we, cfg_index, cfg_data               register write
//
// Press, release, move and ticks without a division go via ST_DONE to the output register.
// An auto tick with steps left runs two 18-step restoring
// divisions by steps_left on the one shared divider, x first, then y.
// in_ready is high only while the sequencer is idle; a finished request may wait in
// the output register while the next one is taken.
// rst is synchronous; it resets control state and out_valid but not result or output data.
module kinetic_scroll_controller
  import ksc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic signed [POS_BITS-1:0] pos_x,
  input  logic signed [POS_BITS-1:0] pos_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       scroll_valid,
  output logic signed [SCR_BITS-1:0] scroll_dx,
  output logic signed [SCR_BITS-1:0] scroll_dy,
  output logic [1:0]                 mode,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [MAXS_W-1:0]          cfg_data
);

  `include "kinetic_scroll_controller_assert.svh"

  seq_state_t                 state, state_next;
  mode_t                      scroll_mode, scroll_mode_next;
  logic [MAXS_W-1:0]          max_speed, max_speed_next;
  logic [STEPS_W-1:0]         decel_steps, decel_steps_next;
  logic [STEPS_W-1:0]         steps_left, steps_left_next;
  logic signed [POS_BITS-1:0] move_x, move_x_next, move_y, move_y_next;
  logic signed [POS_BITS-1:0] tick_x, tick_x_next, tick_y, tick_y_next;
  logic signed [SCR_BITS-1:0] speed_x, speed_x_next, speed_y, speed_y_next;
  logic                       out_valid_next;

  logic [MAG_W-1:0]           cur_mag, cur_mag_next;
  logic                       cur_neg, cur_neg_next;
  logic                       res_valid, res_valid_next;
  logic signed [SCR_BITS-1:0] res_dx, res_dx_next, res_dy, res_dy_next;
  logic [1:0]                 res_mode, res_mode_next;
  logic                       scroll_valid_next;
  logic signed [SCR_BITS-1:0] scroll_dx_next, scroll_dy_next;
  logic [1:0]                 mode_next;

  logic                       accept;
  logic signed [SCR_BITS-1:0] sel_speed;
  logic [SCR_BITS-1:0]        sel_abs;
  logic [MAG_W-1:0]           lim;
  logic signed [SCR_BITS-1:0] lim_s;
  logic [MAG_W-1:0]           clamp_mag;
  logic [MAG_W-1:0]           dec_mag;
  logic [SCR_BITS-1:0]        dec_ext;
  logic signed [SCR_BITS-1:0] dec_val;
  logic signed [POS_BITS:0]   mdx, mdy, tdx, tdy;

  logic                       div_start;
  logic                       div_done;
  logic [MAG_W-1:0]           div_quo;

  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;

  // clamp the selected speed to +-max_speed in fixed point, as a magnitude
  assign sel_speed = (state == ST_DIV_X) ? speed_y : speed_x;
  assign sel_abs   = sel_speed[SCR_BITS-1] ? SCR_BITS'(-sel_speed) : SCR_BITS'(sel_speed);
  assign lim       = {max_speed, {FRAC_BITS{1'b0}}};
  assign lim_s     = signed'({{(SCR_BITS - MAG_W){1'b0}}, lim});
  assign clamp_mag = (sel_abs > {{(SCR_BITS - MAG_W){1'b0}}, lim}) ? lim
                                                                   : sel_abs[MAG_W-1:0];

  // clamped - clamped/steps, truncated toward zero
  assign dec_mag = cur_mag - div_quo;
  assign dec_ext = {{(SCR_BITS - MAG_W){1'b0}}, dec_mag};
  assign dec_val = cur_neg ? signed'(-dec_ext) : signed'(dec_ext);

  assign mdx = {move_x[POS_BITS-1], move_x} - {pos_x[POS_BITS-1], pos_x};
  assign mdy = {move_y[POS_BITS-1], move_y} - {pos_y[POS_BITS-1], pos_y};
  assign tdx = {tick_x[POS_BITS-1], tick_x} - {pos_x[POS_BITS-1], pos_x};
  assign tdy = {tick_y[POS_BITS-1], tick_y} - {pos_y[POS_BITS-1], pos_y};

  ksc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clamp_mag),
    .divisor  (steps_left),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_next        = state;
    scroll_mode_next  = scroll_mode;
    max_speed_next    = max_speed;
    decel_steps_next  = decel_steps;
    steps_left_next   = steps_left;
    move_x_next       = move_x;
    move_y_next       = move_y;
    tick_x_next       = tick_x;
    tick_y_next       = tick_y;
    speed_x_next      = speed_x;
    speed_y_next      = speed_y;
    out_valid_next    = out_valid;
    cur_mag_next      = cur_mag;
    cur_neg_next      = cur_neg;
    res_valid_next    = res_valid;
    res_dx_next       = res_dx;
    res_dy_next       = res_dy;
    res_mode_next     = res_mode;
    scroll_valid_next = scroll_valid;
    scroll_dx_next    = scroll_dx;
    scroll_dy_next    = scroll_dy;
    mode_next         = mode;
    div_start         = 1'b0;

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_SPEED:   max_speed_next   = cfg_data;
        CFG_DECEL_STEPS: decel_steps_next = cfg_data[STEPS_W-1:0];
      endcase
    end

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_valid_next = 1'b0;
          res_dx_next    = '0;
          res_dy_next    = '0;
          state_next     = ST_DONE;
          unique case (scroll_mode)
            MODE_STEADY: begin
              if (op_t'(op) == OP_PRESS) begin
                scroll_mode_next = MODE_PRESSED;
              end
            end
            MODE_PRESSED: begin
              if (op_t'(op) == OP_RELEASE) begin
                scroll_mode_next = MODE_STEADY;
              end else if (op_t'(op) == OP_MOVE) begin
                move_x_next      = pos_x;
                move_y_next      = pos_y;
                tick_x_next      = pos_x;
                tick_y_next      = pos_y;
                scroll_mode_next = MODE_MANUAL;
              end
            end
            MODE_MANUAL: begin
              if (op_t'(op) == OP_MOVE) begin
                res_valid_next = 1'b1;
                res_dx_next    = {mdx, {FRAC_BITS{1'b0}}};
                res_dy_next    = {mdy, {FRAC_BITS{1'b0}}};
                move_x_next    = pos_x;
                move_y_next    = pos_y;
              end else if (op_t'(op) == OP_RELEASE) begin
                scroll_mode_next = MODE_AUTO;
              end else if (op_t'(op) == OP_TICK) begin
                speed_x_next    = {tdx, {FRAC_BITS{1'b0}}};
                speed_y_next    = {tdy, {FRAC_BITS{1'b0}}};
                steps_left_next = decel_steps;
                tick_x_next     = pos_x;
                tick_y_next     = pos_y;
              end
            end
            MODE_AUTO: begin
              if (op_t'(op) == OP_PRESS) begin
                scroll_mode_next = MODE_STEADY;
              end else if (op_t'(op) == OP_TICK) begin
                res_valid_next = 1'b1;
                if (steps_left == '0) begin
                  speed_x_next     = '0;
                  speed_y_next     = '0;
                  scroll_mode_next = MODE_STEADY;
                end else begin
                  div_start    = 1'b1;
                  cur_mag_next = clamp_mag;
                  cur_neg_next = speed_x[SCR_BITS-1];
                  state_next   = ST_DIV_X;
                end
              end
            end
          endcase
          res_mode_next = scroll_mode_next;
        end
      end
      ST_DIV_X: begin
        if (div_done) begin
          speed_x_next = dec_val;
          res_dx_next  = dec_val;
          div_start    = 1'b1;
          cur_mag_next = clamp_mag;
          cur_neg_next = speed_y[SCR_BITS-1];
          state_next   = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        if (div_done) begin
          speed_y_next    = dec_val;
          res_dy_next     = dec_val;
          steps_left_next = steps_left - STEPS_W'(1);
          if (speed_x == '0 && dec_val == '0) begin
            scroll_mode_next = MODE_STEADY;
          end
          res_mode_next = scroll_mode_next;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next    = 1'b1;
          scroll_valid_next = res_valid;
          scroll_dx_next    = res_dx;
          scroll_dy_next    = res_dy;
          mode_next         = res_mode;
          state_next        = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      scroll_mode <= MODE_STEADY;
      max_speed   <= MAX_SPEED_RST;
      decel_steps <= DECEL_STEPS_RST;
      steps_left  <= '0;
      move_x      <= '0;
      move_y      <= '0;
      tick_x      <= '0;
      tick_y      <= '0;
      speed_x     <= '0;
      speed_y     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      scroll_mode <= scroll_mode_next;
      max_speed   <= max_speed_next;
      decel_steps <= decel_steps_next;
      steps_left  <= steps_left_next;
      move_x      <= move_x_next;
      move_y      <= move_y_next;
      tick_x      <= tick_x_next;
      tick_y      <= tick_y_next;
      speed_x     <= speed_x_next;
      speed_y     <= speed_y_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_mag      <= cur_mag_next;
    cur_neg      <= cur_neg_next;
    res_valid    <= res_valid_next;
    res_dx       <= res_dx_next;
    res_dy       <= res_dy_next;
    res_mode     <= res_mode_next;
    scroll_valid <= scroll_valid_next;
    scroll_dx    <= scroll_dx_next;
    scroll_dy    <= scroll_dy_next;
    mode         <= mode_next;
  end

  `KSC_ASSERT_SAME(a_no_scroll_zero, out_valid && !scroll_valid, scroll_dx == '0 && scroll_dy == '0)
  `KSC_ASSERT_SAME(a_div_in_auto, state == ST_DIV_X || state == ST_DIV_Y, scroll_mode == MODE_AUTO)
  `KSC_ASSERT_SAME(a_speed_x_clamped, state == ST_DIV_Y, speed_x <= lim_s && speed_x >= -lim_s)
  `KSC_ASSERT_NEXT(a_steps_dec, state == ST_DIV_Y && div_done, steps_left == $past(steps_left) - STEPS_W'(1))

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import ksc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic signed [POS_BITS-1:0] P_MAX = 16'sh7fff;
  localparam logic signed [POS_BITS-1:0] P_MIN = -16'sh8000;

  typedef struct {
    logic                       scroll_valid;
    logic signed [SCR_BITS-1:0] dx;
    logic signed [SCR_BITS-1:0] dy;
    mode_t                      mode;
  } scroll_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 op = OP_PRESS;
  logic signed [POS_BITS-1:0] pos_x = '0;
  logic signed [POS_BITS-1:0] pos_y = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       scroll_valid;
  logic signed [SCR_BITS-1:0] scroll_dx;
  logic signed [SCR_BITS-1:0] scroll_dy;
  logic [1:0]                 mode;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = CFG_MAX_SPEED;
  logic [MAXS_W-1:0]          cfg_data = '0;

  kinetic_scroll_controller i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .scroll_valid (scroll_valid),
    .scroll_dx    (scroll_dx),
    .scroll_dy    (scroll_dy),
    .mode         (mode),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state and settings
  mode_t  cur_mode = MODE_STEADY;
  longint move_x = 0, move_y = 0;
  longint tick_x = 0, tick_y = 0;
  longint vel_x = 0, vel_y = 0;
  int     steps_left = 0;
  int     lim_speed = int'(MAX_SPEED_RST);
  int     steps_cfg = int'(DECEL_STEPS_RST);

  scroll_t scroll_q[$];

  int  n_sent = 0;
  int  n_checked = 0;
  int  n_settings = 0;
  int  errors = 0;
  int  cycle_cnt = 0;
  int  rx_hold = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  logic signed [POS_BITS-1:0] cur_x = '0;
  logic signed [POS_BITS-1:0] cur_y = '0;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic longint clamp_speed(longint v);
    longint lim;
    lim = longint'(lim_speed) << FRAC_BITS;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  task automatic predict_scroll(op_t o, logic signed [POS_BITS-1:0] x,
                                logic signed [POS_BITS-1:0] y);
    scroll_t r;
    longint  one;
    longint  cx, cy;
    one = longint'(1) << FRAC_BITS;
    r.scroll_valid = 1'b0;
    r.dx = '0;
    r.dy = '0;
    case (cur_mode)
      MODE_STEADY: begin
        if (o == OP_PRESS) cur_mode = MODE_PRESSED;
      end
      MODE_PRESSED: begin
        if (o == OP_RELEASE) begin
          cur_mode = MODE_STEADY;
        end else if (o == OP_MOVE) begin
          move_x = x;
          move_y = y;
          tick_x = x;
          tick_y = y;
          cur_mode = MODE_MANUAL;
        end
      end
      MODE_MANUAL: begin
        if (o == OP_MOVE) begin
          r.scroll_valid = 1'b1;
          r.dx = SCR_BITS'((move_x - x) * one);
          r.dy = SCR_BITS'((move_y - y) * one);
          move_x = x;
          move_y = y;
        end else if (o == OP_RELEASE) begin
          cur_mode = MODE_AUTO;
        end else if (o == OP_TICK) begin
          vel_x = (tick_x - x) * one;
          vel_y = (tick_y - y) * one;
          steps_left = steps_cfg;
          tick_x = x;
          tick_y = y;
        end
      end
      default: begin
        if (o == OP_PRESS) begin
          cur_mode = MODE_STEADY;
        end else if (o == OP_TICK) begin
          if (steps_left > 0) begin
            cx = clamp_speed(vel_x);
            cy = clamp_speed(vel_y);
            vel_x = cx - cx / longint'(steps_left);
            vel_y = cy - cy / longint'(steps_left);
            steps_left--;
          end else begin
            vel_x = 0;
            vel_y = 0;
          end
          r.scroll_valid = 1'b1;
          r.dx = SCR_BITS'(vel_x);
          r.dy = SCR_BITS'(vel_y);
          if (vel_x == 0 && vel_y == 0) cur_mode = MODE_STEADY;
        end
      end
    endcase
    r.mode = cur_mode;
    scroll_q.push_back(r);
  endtask

  task automatic send_event(op_t o, logic signed [POS_BITS-1:0] x,
                            logic signed [POS_BITS-1:0] y);
    int gap;
    gap = tx_idle ? int'($urandom_range(0, 10)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    pos_x <= x;
    pos_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_scroll(o, x, y);
    n_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (scroll_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_settings(int unsigned mx, int unsigned st);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_SPEED;
    cfg_data <= MAXS_W'(mx);
    @(posedge clk);
    cfg_index <= CFG_DECEL_STEPS;
    cfg_data <= {5'($urandom), 5'(st)};
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_speed = int'(mx & 32'h3ff);
    steps_cfg = int'(st & 32'h1f);
    n_settings++;
  endtask

  function automatic logic signed [POS_BITS-1:0] wander(logic signed [POS_BITS-1:0] p);
    int d;
    if ($urandom_range(0, 15) == 0) return POS_BITS'($urandom);
    d = int'($urandom_range(0, 600)) - 300;
    return POS_BITS'(int'(p) + d);
  endfunction

  task automatic check_scroll();
    scroll_t e;
    if (scroll_q.size() == 0) begin
      $error("unexpected result: scroll_valid %0d dx %0d dy %0d mode %0d",
             scroll_valid, scroll_dx, scroll_dy, mode);
      errors++;
      return;
    end
    e = scroll_q.pop_front();
    n_checked++;
    if (scroll_valid !== e.scroll_valid) begin
      $error("scroll_valid: expected %0d, got %0d", e.scroll_valid, scroll_valid);
      errors++;
    end
    if (scroll_dx !== e.dx) begin
      $error("scroll_dx: expected %0d, got %0d", e.dx, scroll_dx);
      errors++;
    end
    if (scroll_dy !== e.dy) begin
      $error("scroll_dy: expected %0d, got %0d", e.dy, scroll_dy);
      errors++;
    end
    if (mode !== e.mode) begin
      $error("mode: expected %0d, got %0d", e.mode, mode);
      errors++;
    end
  endtask

  initial begin : result_sink
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = rx_idle ? int'($urandom_range(0, 10)) : 0;
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_scroll();
    end
  end

  // press, drag with ticks, then mostly release and coast until steady or 40 events pass
  task automatic run_gesture();
    int n;
    int guard;
    cur_x = wander(cur_x);
    cur_y = wander(cur_y);
    send_event(OP_PRESS, cur_x, cur_y);
    send_event(OP_MOVE, cur_x, cur_y);
    n = $urandom_range(1, 12);
    repeat (n) begin
      cur_x = wander(cur_x);
      cur_y = wander(cur_y);
      if ($urandom_range(0, 2) == 0) send_event(OP_TICK, cur_x, cur_y);
      else send_event(OP_MOVE, cur_x, cur_y);
    end
    cur_x = wander(cur_x);
    cur_y = wander(cur_y);
    send_event(OP_TICK, cur_x, cur_y);
    if ($urandom_range(0, 9) == 0) return;
    send_event(OP_RELEASE, cur_x, cur_y);
    guard = 0;
    while (cur_mode == MODE_AUTO && guard < 40) begin
      case ($urandom_range(0, 15))
        0:       send_event(OP_PRESS, POS_BITS'($urandom), POS_BITS'($urandom));
        1:       send_event(OP_MOVE, POS_BITS'($urandom), POS_BITS'($urandom));
        default: send_event(OP_TICK, POS_BITS'($urandom), POS_BITS'($urandom));
      endcase
      guard++;
    end
  endtask

  task automatic test_directed_edges();
    // reset settings; ignored events while steady
    send_event(OP_TICK, P_MAX, P_MIN);
    send_event(OP_RELEASE, P_MIN, P_MAX);
    send_event(OP_MOVE, P_MAX, P_MAX);
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_RELEASE, 16'sd0, 16'sd0);
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_TICK, P_MIN, P_MIN);
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_MOVE, P_MAX, P_MIN);
    // full-scale drag and tick capture
    send_event(OP_MOVE, P_MIN, P_MAX);
    send_event(OP_TICK, P_MIN, P_MAX);
    send_event(OP_RELEASE, P_MIN, P_MAX);
    send_event(OP_TICK, 16'sd0, 16'sd0);
    send_event(OP_TICK, 16'sd0, 16'sd0);
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    // zero clamp ends coasting at once
    write_settings(0, 5);
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_MOVE, 16'sd10, -16'sd10);
    send_event(OP_TICK, -16'sd90, 16'sd90);
    send_event(OP_RELEASE, 16'sd0, 16'sd0);
    send_event(OP_TICK, 16'sd0, 16'sd0);
    // zero step count ends coasting at once
    write_settings(1023, 0);
    send_event(OP_PRESS, 16'sd0, 16'sd0);
    send_event(OP_MOVE, 16'sd0, 16'sd0);
    send_event(OP_TICK, -16'sd100, 16'sd50);
    send_event(OP_RELEASE, 16'sd0, 16'sd0);
    send_event(OP_TICK, 16'sd0, 16'sd0);
  endtask

  task automatic test_random_gestures();
    int goal;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       write_settings(1023, 31);
        1:       write_settings(1, 1);
        2:       write_settings(3, 7);
        default: write_settings($urandom_range(0, 1023), $urandom_range(0, 31));
      endcase
      goal = n_sent + 290;
      while (n_sent < goal) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4))
            send_event(op_t'($urandom_range(0, 3)), POS_BITS'($urandom), POS_BITS'($urandom));
        end else begin
          run_gesture();
        end
      end
    end
  endtask

  task automatic test_backpressure();
    write_settings(200, 31);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 400;
    repeat (4) run_gesture();
    // hold the sender until the sink drains
    wait_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_backpressure();
    test_random_gestures();
    wait_idle();
    repeat (60) @(posedge clk);
    $display("%0d events sent, %0d results checked", n_sent, n_checked);
    $display("covered %0d register settings incl. zero and full-scale clamp and steps",
             n_settings);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- kinetic_scroll_controller.f -----
+incdir+hdl
hdl/ksc_pkg.sv
hdl/ksc_div.sv
hdl/kinetic_scroll_controller.sv
tb/tb_top.sv
